// File: src/fcba_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and codes of the frame channel bin averager
// no dependencies; used by the top level, the checker and the testbench
package fcba_pkg;

  localparam int unsigned MAX_CHANNELS = 64;
  localparam int unsigned MAX_WIDTH    = 4095;
  localparam int unsigned FRAME_LIMIT  = 4096;

  localparam int unsigned ADDR_W      = $clog2(MAX_CHANNELS);
  localparam int unsigned CHAN_W      = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned LEN_W       = 13;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned WIDTH_W     = 12;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned ACC_W       = 28;
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned MEAN_W      = 24;
  localparam int unsigned QUOT_W      = MEAN_W;
  localparam int unsigned DIV_CNT_W   = $clog2(QUOT_W);
  localparam int unsigned HI_W        = ACC_W - 1 - (QUOT_W - FRAC_W);
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 13;

  localparam logic [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CHANNEL_COUNT   = 2'd0,
    CFG_FRAME_LENGTH    = 2'd1,
    CFG_ALTERNATE_SIGNS = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

// File: src/fcba_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read data
// no dependencies
module fcba_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/frame_channel_bin_averager_top.sv
`timescale 1ns / 1ps
// frame channel bin averager: channel table ram, accumulator, radix-2 divider
// depends on fcba_pkg and fcba_ram
//
// Input channel (valid/ready): command 0 loads a channel width into the table,
// command 1 delivers one sample of the current frame. Output channel
// (valid/ready): one channel mean per completed channel, 8 fraction bits.
// The configuration port is a plain write port; the user must use it only while idle, the block does not enforce this.
// A table write is taken in the idle state. A sample that closes no channel
// passes a table read, then accumulate. A sample that closes a channel
// passes these steps until the mean shows at the output: table read,
// accumulate, 24 quotient bits of the radix-2 divider at one bit per cycle,
// and the load of the output register. No new transaction is taken until
// the mean is loaded; a mean whose quotient reaches 2^24 skips the divider.
// The output register holds a finished mean while the receiver stalls and
// the block goes on taking new transactions; only a second mean waits for it.
// Reset clears the frame position, channel, fill, accumulator and parity and
// sets channel count 1, frame length 1, sign alternation off. The width
// table has no reset: every entry must be written before it is used.
module frame_channel_bin_averager_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fcba_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [fcba_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 in_command_i,
  input  logic [fcba_pkg::ADDR_W-1:0]          in_entry_index_i,
  input  logic [fcba_pkg::WIDTH_W-1:0]         in_width_value_i,
  input  logic signed [fcba_pkg::SAMPLE_W-1:0] in_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [fcba_pkg::ADDR_W-1:0]          out_channel_o,
  output logic signed [fcba_pkg::MEAN_W-1:0]   out_mean_value_o,
  output logic                                 out_odd_frame_o
);

  // configuration
  logic [fcba_pkg::COUNT_W-1:0] cfg_count_q;
  logic [fcba_pkg::LEN_W-1:0]   cfg_length_q;
  logic                         cfg_alt_q;

  // frame state
  fcba_pkg::state_e                    state_q, state_d;
  logic signed [fcba_pkg::ACC_W-1:0]   acc_q, acc_d;
  logic [fcba_pkg::WIDTH_W-1:0]        fill_q, fill_d;
  logic [fcba_pkg::POS_W-1:0]          pos_q, pos_d;
  logic [fcba_pkg::CHAN_W-1:0]         chan_idx_q, chan_d;
  logic                                parity_q, parity_d;
  logic signed [fcba_pkg::SAMPLE_W-1:0] sample_q;

  // divider
  logic [fcba_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic [fcba_pkg::WIDTH_W-1:0]   div_rem_q;
  logic [fcba_pkg::QUOT_W-1:0]    div_shift_q;
  logic [fcba_pkg::WIDTH_W-1:0]   div_den_q;
  logic                           div_neg_q;
  logic                           div_ovf_q;
  logic [fcba_pkg::ADDR_W-1:0]    div_chan_q;
  logic                           div_odd_q;

  // output register
  logic                          out_valid_q;
  logic [fcba_pkg::ADDR_W-1:0]   out_chan_q;
  logic [fcba_pkg::MEAN_W-1:0]   out_mean_q;
  logic                          out_odd_q;

  // ram
  logic                         ram_we, ram_re;
  logic [fcba_pkg::WIDTH_W-1:0] ram_wdata, ram_rdata;

  // control strobes
  logic div_load, div_step, out_load;

  // datapath
  logic [fcba_pkg::COUNT_W-1:0]      count_eff;
  logic [fcba_pkg::LEN_W-1:0]        len_eff;
  logic [fcba_pkg::WIDTH_W-1:0]      w_eff;
  logic                              used, chan_done, frame_end, div_ovf;
  logic [fcba_pkg::WIDTH_W:0]        fill_sum;
  logic [fcba_pkg::LEN_W-1:0]        pos_next;
  logic signed [fcba_pkg::ACC_W-1:0] acc_sum;
  logic [fcba_pkg::ACC_W-1:0]        mag;
  logic [fcba_pkg::HI_W-1:0]         div_hi;
  logic [fcba_pkg::WIDTH_W:0]        trial, trial_sub;
  logic                              trial_ge;
  logic                              mean_sat;
  logic [fcba_pkg::MEAN_W-1:0]       mean_d;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q  <= fcba_pkg::COUNT_W'(1);
      cfg_length_q <= fcba_pkg::LEN_W'(1);
      cfg_alt_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fcba_pkg::CFG_CHANNEL_COUNT:   cfg_count_q  <= cfg_data_i[fcba_pkg::COUNT_W-1:0];
        fcba_pkg::CFG_FRAME_LENGTH:    cfg_length_q <= cfg_data_i[fcba_pkg::LEN_W-1:0];
        fcba_pkg::CFG_ALTERNATE_SIGNS: cfg_alt_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign count_eff = (cfg_count_q == '0) ? fcba_pkg::COUNT_W'(1) :
                     (cfg_count_q > fcba_pkg::COUNT_W'(fcba_pkg::MAX_CHANNELS)) ?
                     fcba_pkg::COUNT_W'(fcba_pkg::MAX_CHANNELS) : cfg_count_q;
  assign len_eff   = (cfg_length_q == '0) ? fcba_pkg::LEN_W'(1) :
                     (cfg_length_q > fcba_pkg::LEN_W'(fcba_pkg::FRAME_LIMIT)) ?
                     fcba_pkg::LEN_W'(fcba_pkg::FRAME_LIMIT) : cfg_length_q;

  // width table
  assign ram_wdata = (in_width_value_i > fcba_pkg::WIDTH_W'(fcba_pkg::MAX_WIDTH)) ?
                     fcba_pkg::WIDTH_W'(fcba_pkg::MAX_WIDTH) : in_width_value_i;

  fcba_ram #(
    .Width(fcba_pkg::WIDTH_W),
    .Depth(fcba_pkg::MAX_CHANNELS)
  ) u_width_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(in_entry_index_i),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(chan_idx_q[fcba_pkg::ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  // accumulate step
  assign w_eff     = (ram_rdata == '0) ? fcba_pkg::WIDTH_W'(1) : ram_rdata;
  assign used      = ({1'b0, chan_idx_q} < {1'b0, count_eff});
  assign acc_sum   = acc_q + fcba_pkg::ACC_W'(sample_q);
  assign fill_sum  = {1'b0, fill_q} + (fcba_pkg::WIDTH_W + 1)'(1);
  assign chan_done = used && (fill_sum >= {1'b0, w_eff});
  assign pos_next  = {1'b0, pos_q} + fcba_pkg::LEN_W'(1);
  assign frame_end = (pos_next >= len_eff);
  assign mag       = acc_sum[fcba_pkg::ACC_W-1] ? fcba_pkg::ACC_W'(-acc_sum) :
                                                  fcba_pkg::ACC_W'(acc_sum);
  // quotient of at least 2^24 saturates in any case
  assign div_hi    = mag[fcba_pkg::ACC_W-2 -: fcba_pkg::HI_W];
  assign div_ovf   = ({1'b0, div_hi} >= w_eff);

  // divider step
  assign trial     = {div_rem_q, div_shift_q[fcba_pkg::QUOT_W-1]};
  assign trial_ge  = (trial >= {1'b0, div_den_q});
  assign trial_sub = trial - {1'b0, div_den_q};

  // mean with sign and saturation
  assign mean_sat = div_ovf_q | div_shift_q[fcba_pkg::QUOT_W-1];
  always_comb begin
    if (div_neg_q) begin
      mean_d = mean_sat ? fcba_pkg::MEAN_MIN : fcba_pkg::MEAN_W'(-div_shift_q);
    end else begin
      mean_d = mean_sat ? fcba_pkg::MEAN_MAX : div_shift_q;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcba_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    div_load   = 1'b0;
    div_step   = 1'b0;
    out_load   = 1'b0;
    acc_d      = acc_q;
    fill_d     = fill_q;
    pos_d      = pos_q;
    chan_d     = chan_idx_q;
    parity_d   = parity_q;
    case (state_q)
      fcba_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_command_i == fcba_pkg::CMD_WRITE) begin
            ram_we = 1'b1;
          end else begin
            ram_re  = 1'b1;
            state_d = fcba_pkg::ST_CALC;
          end
        end
      end
      fcba_pkg::ST_CALC: begin
        if (used) begin
          acc_d  = acc_sum;
          fill_d = fill_sum[fcba_pkg::WIDTH_W-1:0];
        end
        if (chan_done) begin
          div_load = 1'b1;
          chan_d   = chan_idx_q + fcba_pkg::CHAN_W'(1);
          fill_d   = '0;
          acc_d    = '0;
          state_d  = div_ovf ? fcba_pkg::ST_OUT : fcba_pkg::ST_DIV;
        end else begin
          state_d = fcba_pkg::ST_IDLE;
        end
        if (frame_end) begin
          pos_d    = '0;
          chan_d   = '0;
          fill_d   = '0;
          acc_d    = '0;
          parity_d = ~parity_q;
        end else begin
          pos_d = pos_next[fcba_pkg::POS_W-1:0];
        end
      end
      fcba_pkg::ST_DIV: begin
        div_step = 1'b1;
        if (div_cnt_q == '0) begin
          state_d = fcba_pkg::ST_OUT;
        end
      end
      fcba_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = fcba_pkg::ST_IDLE;
        end
      end
      default: state_d = fcba_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      fill_q      <= '0;
      pos_q       <= '0;
      chan_idx_q  <= '0;
      parity_q    <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q      <= acc_d;
      fill_q     <= fill_d;
      pos_q      <= pos_d;
      chan_idx_q <= chan_d;
      parity_q   <= parity_d;
      if (div_load) begin
        div_cnt_q <= fcba_pkg::DIV_CNT_W'(fcba_pkg::QUOT_W - 1);
      end else if (div_step) begin
        div_cnt_q <= div_cnt_q - fcba_pkg::DIV_CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      sample_q <= in_sample_i;
    end
    if (div_load) begin
      div_rem_q   <= {1'b0, div_hi};
      div_shift_q <= {mag[fcba_pkg::QUOT_W-fcba_pkg::FRAC_W-1:0], {fcba_pkg::FRAC_W{1'b0}}};
      div_den_q   <= w_eff;
      div_neg_q   <= acc_sum[fcba_pkg::ACC_W-1] ^ (cfg_alt_q & parity_q);
      div_ovf_q   <= div_ovf;
      div_chan_q  <= chan_idx_q[fcba_pkg::ADDR_W-1:0];
      div_odd_q   <= parity_q;
    end else if (div_step) begin
      div_rem_q   <= trial_ge ? trial_sub[fcba_pkg::WIDTH_W-1:0] :
                                trial[fcba_pkg::WIDTH_W-1:0];
      div_shift_q <= {div_shift_q[fcba_pkg::QUOT_W-2:0], trial_ge};
    end
    if (out_load) begin
      out_chan_q <= div_chan_q;
      out_mean_q <= mean_d;
      out_odd_q  <= div_odd_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_channel_o    = out_chan_q;
  assign out_mean_value_o = out_mean_q;
  assign out_odd_frame_o  = out_odd_q;

`ifndef ASSERT_OFF
  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fcba_pkg::ST_DIV && div_cnt_q == '0) |=> state_q == fcba_pkg::ST_OUT)
    else $error("divider did not hand over to output stage");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fcba_pkg::ST_DIV) |-> (div_rem_q < div_den_q))
    else $error("partial remainder not below divisor");

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chan_idx_q <= fcba_pkg::CHAN_W'(fcba_pkg::MAX_CHANNELS))
    else $error("channel index beyond table");

  a_sample_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_command_i == fcba_pkg::CMD_SAMPLE)
      |=> state_q == fcba_pkg::ST_CALC)
    else $error("sample transaction not followed by table read");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("mean not presented after load");
`endif

endmodule

// File: test/frame_channel_bin_averager_checker.sv
`timescale 1ns / 1ps
// transaction monitor, mean predictor and result comparison for the bin averager
// depends on fcba_pkg; placed beside the block by tb_frame_channel_bin_averager_top
module frame_channel_bin_averager_checker
  import fcba_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic                       in_command_i,
  input  logic [ADDR_W-1:0]          in_entry_index_i,
  input  logic [WIDTH_W-1:0]         in_width_value_i,
  input  logic signed [SAMPLE_W-1:0] in_sample_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [ADDR_W-1:0]          out_channel_i,
  input  logic signed [MEAN_W-1:0]   out_mean_value_i,
  input  logic                       out_odd_frame_i,
  output int                         mismatch_count_o,
  output int                         pending_o
);

  localparam longint MEAN_HI = (longint'(1) <<< (MEAN_W - 1)) - 1;
  localparam longint MEAN_LO = -(longint'(1) <<< (MEAN_W - 1));
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [ADDR_W-1:0]        channel;
    logic signed [MEAN_W-1:0] mean;
    logic                     odd;
  } bin_mean_t;

  logic [WIDTH_W-1:0] width_table [MAX_CHANNELS];
  longint             bin_sum;
  int unsigned        frame_pos;
  int unsigned        bin_idx;
  int unsigned        bin_fill;
  logic               frame_odd;
  logic [COUNT_W-1:0] count_reg;
  logic [LEN_W-1:0]   length_reg;
  logic               alternate_reg;
  bin_mean_t          mean_queue [$];
  bin_mean_t          seen;
  bin_mean_t          due;
  bin_mean_t          fresh;

  function automatic bit take_sample(input logic signed [SAMPLE_W-1:0] smp,
                                     output bin_mean_t res);
    int unsigned n_chan;
    int unsigned n_len;
    int unsigned w;
    longint      q;
    bit          got;
    got = 1'b0;
    res = '0;
    n_chan = (count_reg == 0) ? 1 : ((count_reg > MAX_CHANNELS) ? MAX_CHANNELS : count_reg);
    n_len = (length_reg == 0) ? 1 : ((length_reg > FRAME_LIMIT) ? FRAME_LIMIT : length_reg);
    if (bin_idx < n_chan) begin
      w = (width_table[bin_idx] == 0) ? 1 : width_table[bin_idx];
      bin_sum += smp;
      bin_fill++;
      if (bin_fill >= w) begin
        q = (bin_sum * 256) / longint'(w);
        if (alternate_reg && frame_odd) q = -q;
        if (q > MEAN_HI) q = MEAN_HI;
        if (q < MEAN_LO) q = MEAN_LO;
        res.channel = bin_idx[ADDR_W-1:0];
        res.mean = q[MEAN_W-1:0];
        res.odd = frame_odd;
        got = 1'b1;
        bin_idx++;
        bin_fill = 0;
        bin_sum = 0;
      end
    end
    frame_pos++;
    // frame end also drops a channel cut off part way
    if (frame_pos >= n_len) begin
      frame_pos = 0;
      bin_idx = 0;
      bin_fill = 0;
      bin_sum = 0;
      frame_odd = ~frame_odd;
    end
    return got;
  endfunction

  task automatic report(input string what, input bin_mean_t exp_m, input bin_mean_t act_m);
    mismatch_count_o++;
    if (mismatch_count_o <= REPORT_LIMIT) begin
      $display("%0t %s: expected ch %0d mean %0d odd %0d, got ch %0d mean %0d odd %0d",
               $time, what, exp_m.channel, $signed(exp_m.mean), exp_m.odd,
               act_m.channel, $signed(act_m.mean), act_m.odd);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_sum = 0;
      frame_pos = 0;
      bin_idx = 0;
      bin_fill = 0;
      frame_odd = 1'b0;
      count_reg = 1;
      length_reg = 1;
      alternate_reg = 1'b0;
      mean_queue.delete();
      mismatch_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen = {out_channel_i, out_mean_value_i, out_odd_frame_i};
        if (mean_queue.size() == 0) begin
          report("unexpected mean", '0, seen);
        end else begin
          due = mean_queue.pop_front();
          if (seen.channel !== due.channel || seen.mean !== due.mean || seen.odd !== due.odd)
            report("mean mismatch", due, seen);
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CHANNEL_COUNT:   count_reg = cfg_data_i[COUNT_W-1:0];
          CFG_FRAME_LENGTH:    length_reg = cfg_data_i[LEN_W-1:0];
          CFG_ALTERNATE_SIGNS: alternate_reg = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (in_command_i == CMD_WRITE) begin
          width_table[in_entry_index_i] =
            (in_width_value_i > MAX_WIDTH) ? WIDTH_W'(MAX_WIDTH) : in_width_value_i;
        end else if (take_sample(in_sample_i, fresh)) begin
          mean_queue.push_back(fresh);
        end
      end
      pending_o = mean_queue.size();
    end
  end

endmodule

// File: test/tb_frame_channel_bin_averager_top.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, stimulus and verdict for frame_channel_bin_averager_top
// depends on fcba_pkg, the block itself and frame_channel_bin_averager_checker
module tb_frame_channel_bin_averager_top;
  import fcba_pkg::*;

  localparam int ITEM_GOAL   = 1100;
  localparam int IDLE_PCT    = 19;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 32;
  localparam int DRAIN_LIMIT = 5000;
  localparam int LONG_WIDTH  = 400;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [CFG_INDEX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_command;
  logic [ADDR_W-1:0]          in_entry_index;
  logic [WIDTH_W-1:0]         in_width_value;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       out_valid;
  logic                       out_ready;
  logic [ADDR_W-1:0]          out_channel;
  logic signed [MEAN_W-1:0]   out_mean_value;
  logic                       out_odd_frame;

  int                         mismatch_count;
  int                         pending_count;
  int                         items_sent;
  int                         cur_count;
  logic [MAX_CHANNELS-1:0]    loaded;
  bit                         steady;
  bit                         hold_req;

  frame_channel_bin_averager_top dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .in_command_i     (in_command),
    .in_entry_index_i (in_entry_index),
    .in_width_value_i (in_width_value),
    .in_sample_i      (in_sample),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .out_channel_o    (out_channel),
    .out_mean_value_o (out_mean_value),
    .out_odd_frame_o  (out_odd_frame)
  );

  frame_channel_bin_averager_checker mean_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_command_i     (in_command),
    .in_entry_index_i (in_entry_index),
    .in_width_value_i (in_width_value),
    .in_sample_i      (in_sample),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_channel_i    (out_channel),
    .out_mean_value_i (out_mean_value),
    .out_odd_frame_i  (out_odd_frame),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb_frame_channel_bin_averager_top NOT OK");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic offer(input logic cmd, input logic [ADDR_W-1:0] idx,
                       input logic [WIDTH_W-1:0] wv, input logic [SAMPLE_W-1:0] smp);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_entry_index <= idx;
    in_width_value <= wv;
    in_sample <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_entry(input int idx, input int w);
    offer(CMD_WRITE, idx[ADDR_W-1:0], WIDTH_W'(w), SAMPLE_W'($urandom));
    loaded[idx] = 1'b1;
  endtask

  task automatic push_sample(input logic [SAMPLE_W-1:0] smp);
    offer(CMD_SAMPLE, ADDR_W'($urandom), WIDTH_W'($urandom), smp);
  endtask

  // wait until every expected mean is out, then let a closing sample finish
  task automatic settle();
    int waited;
    @(negedge clk);
    in_valid <= 1'b0;
    for (waited = 0; pending_count != 0 && waited < DRAIN_LIMIT; waited++) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input int data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CHANNEL_COUNT) cur_count = data & 'h7F;
  endtask

  // every entry that can be read under the current channel count gets a width
  task automatic prime_table();
    int n;
    n = (cur_count == 0) ? 1 : ((cur_count > MAX_CHANNELS) ? MAX_CHANNELS : cur_count);
    for (int i = 0; i < n; i++) begin
      if (!loaded[i]) load_entry(i, WIDTH_W'($urandom_range(1, 6)));
    end
  endtask

  function automatic logic [WIDTH_W-1:0] random_width();
    int pick;
    pick = $urandom_range(9);
    if (pick < 7) return WIDTH_W'($urandom_range(1, 6));
    if (pick < 9) return WIDTH_W'($urandom_range(0, 40));
    return WIDTH_W'($urandom);
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(11))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // a long channel at full scale in a frame of the longest length
  task automatic long_frame();
    logic [SAMPLE_W-1:0] level;
    settle();
    set_reg(CFG_FRAME_LENGTH, 1);
    push_sample(random_sample());
    settle();
    set_reg(CFG_FRAME_LENGTH, 8191);
    set_reg(CFG_CHANNEL_COUNT, 2);
    load_entry(0, LONG_WIDTH);
    load_entry(1, LONG_WIDTH);
    level = $urandom_range(1) ? 16'h7fff : 16'h8000;
    repeat (LONG_WIDTH) push_sample(level);
    repeat (4) push_sample(random_sample());
  endtask

  initial begin
    int phase;
    int n;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_CHANNEL_COUNT;
    cfg_data = '0;
    in_valid = 1'b0;
    in_command = CMD_WRITE;
    in_entry_index = '0;
    in_width_value = '0;
    in_sample = '0;
    steady = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    loaded = '0;
    cur_count = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // one-sample frames, zero width, full-scale samples
    load_entry(0, 0);
    push_sample(16'h7fff);
    push_sample(16'h8000);
    load_entry(63, 4095);
    settle();
    // alternating signs, negated most negative mean saturates
    set_reg(CFG_ALTERNATE_SIGNS, 1);
    push_sample(16'h8000);
    push_sample(16'h8000);
    push_sample(16'h7fff);
    push_sample(16'hffff);
    push_sample(16'h0001);
    settle();
    // channels cut off at frame end, spare register index, width shrunk mid channel
    set_reg(CFG_CHANNEL_COUNT, 3);
    set_reg(CFG_FRAME_LENGTH, 6);
    set_reg(CFG_SPARE, 'h1fff);
    load_entry(0, 1);
    load_entry(1, 2);
    load_entry(2, 4);
    repeat (6) push_sample(random_sample());
    push_sample(random_sample());
    push_sample(random_sample());
    load_entry(1, 1);
    push_sample(random_sample());

    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      settle();
      steady = (phase == 2);
      case ($urandom_range(9))
        0:       set_reg(CFG_CHANNEL_COUNT, 0);
        1:       set_reg(CFG_CHANNEL_COUNT, MAX_CHANNELS);
        2:       set_reg(CFG_CHANNEL_COUNT, 127);
        3:       set_reg(CFG_CHANNEL_COUNT, $urandom_range(1, 127));
        default: set_reg(CFG_CHANNEL_COUNT, $urandom_range(1, 8));
      endcase
      case ($urandom_range(9))
        0:       set_reg(CFG_FRAME_LENGTH, 0);
        1:       set_reg(CFG_FRAME_LENGTH, 1);
        2:       set_reg(CFG_FRAME_LENGTH, FRAME_LIMIT);
        3:       set_reg(CFG_FRAME_LENGTH, $urandom_range(FRAME_LIMIT + 1, 8191));
        default: set_reg(CFG_FRAME_LENGTH, $urandom_range(2, 60));
      endcase
      set_reg(CFG_ALTERNATE_SIGNS, $urandom_range(1));
      if ($urandom_range(3) == 0) set_reg(CFG_SPARE, $urandom);
      prime_table();
      if (phase == 4) hold_req = 1'b1;
      n = $urandom_range(30, 90);
      repeat (n) begin
        if ($urandom_range(99) < 15) load_entry($urandom_range(0, MAX_CHANNELS - 1),
                                                random_width());
        else push_sample(random_sample());
      end
      if (phase == 1) long_frame();
      phase++;
    end
    settle();

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb_frame_channel_bin_averager_top OK");
    end else begin
      $display("tb_frame_channel_bin_averager_top NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/fcba_pkg.sv
src/fcba_ram.sv
src/frame_channel_bin_averager_top.sv
test/frame_channel_bin_averager_checker.sv
test/tb_frame_channel_bin_averager_top.sv
